// ===== design/temporal_frame_combiner_top_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the temporal frame combiner
// Shared property wrappers used by the design files.
// ---------------------------------------------------------------------------
`ifndef TEMPORAL_FRAME_COMBINER_TOP_DEFINES_SVH
`define TEMPORAL_FRAME_COMBINER_TOP_DEFINES_SVH

// Implication checked every clock edge outside reset.
`define TFC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication checked every clock edge outside reset.
`define TFC_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== design/tfc_pkg.sv =====
// ---------------------------------------------------------------------------
// Temporal frame combiner package
// Shared constants, mode codes and the fold function.
// ---------------------------------------------------------------------------
package tfc_pkg;

  localparam int unsigned MAX_FRAMES_DEF = 8;
  localparam int unsigned MAX_PIXELS_DEF = 16384;
  localparam int unsigned CFG_W          = 15;
  localparam int unsigned CFG_IDX_W      = 2;
  localparam int unsigned SUM_W          = 12;

  localparam logic [CFG_IDX_W-1:0] REG_OP_MODE      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_DEPTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_PIXELS = 2'd2;

  localparam logic [3:0] MODE_AVG = 4'd0;
  localparam logic [3:0] MODE_XOR = 4'd1;
  localparam logic [3:0] MODE_OR  = 4'd2;
  localparam logic [3:0] MODE_AND = 4'd3;
  localparam logic [3:0] MODE_ADD = 4'd4;
  localparam logic [3:0] MODE_SUB = 4'd5;
  localparam logic [3:0] MODE_MUL = 4'd6;
  localparam logic [3:0] MODE_MIN = 4'd7;
  localparam logic [3:0] MODE_MAX = 4'd8;

  function automatic logic [7:0] fold8(input logic [3:0] mode, input logic [7:0] y,
                                       input logic [7:0] x);
    logic [15:0] prod;
    logic [7:0]  r;
    prod = y * x;
    case (mode)
      MODE_XOR: r = y ^ x;
      MODE_OR:  r = y | x;
      MODE_AND: r = y & x;
      MODE_ADD: r = y + x;
      MODE_SUB: r = y - x;
      MODE_MUL: r = prod[7:0];
      MODE_MIN: r = (x < y) ? x : y;
      MODE_MAX: r = (x > y) ? x : y;
      default:  r = y;
    endcase
    return r;
  endfunction

endpackage

// ===== design/tfc_store.sv =====
// ---------------------------------------------------------------------------
// Frame store
// Single-port pixel memory, slot-major, with registered read data.
// ---------------------------------------------------------------------------
module tfc_store #(
  parameter int unsigned ADDR_W = 17
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] addr,
  input  logic [23:0]       wdata,
  output logic [23:0]       rdata
);

  logic [23:0] mem [0:(1<<ADDR_W)-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== design/tfc_divider.sv =====
// ---------------------------------------------------------------------------
// Channel divider
// Restoring divider, one quotient bit per cycle, for a 12-bit sum by depth.
// ---------------------------------------------------------------------------
module tfc_divider
  import tfc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [SUM_W-1:0] dividend,
  input  logic [3:0]       divisor,
  output logic             done,
  output logic [7:0]       quotient
);

  logic [SUM_W-1:0] q_r;
  logic [4:0]  rem_r;
  logic [3:0]  cnt_r;
  logic        busy_r;
  logic [4:0]  trial;
  logic [4:0]  rem_shift;

  assign rem_shift = {rem_r[3:0], q_r[SUM_W-1]};
  assign trial     = rem_shift - {1'b0, divisor};
  assign quotient  = q_r[7:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done   <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        q_r    <= dividend;
        rem_r  <= '0;
        cnt_r  <= 4'd0;
      end else if (busy_r) begin
        if (!trial[4]) begin
          rem_r <= trial;
          q_r   <= {q_r[SUM_W-2:0], 1'b1};
        end else begin
          rem_r <= rem_shift;
          q_r   <= {q_r[SUM_W-2:0], 1'b0};
        end
        cnt_r <= cnt_r + 4'd1;
        if (cnt_r == 4'(SUM_W - 1)) begin
          busy_r <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== design/temporal_frame_combiner_top.sv =====
// ---------------------------------------------------------------------------
// Temporal frame combiner
// Channel      Signals                                    Direction
// input        in_valid, in_stall, in_red/green/blue      into block
// result       out_valid, out_stall, out_red/green/blue   out of block
// config       cfg_we, cfg_index, cfg_data                into block
// Each item is accepted, written to the store (to every slot on the first
// frame, to one slot otherwise), addressed, read and accumulated over the
// depth, divided per channel in average mode and then output; the single
// memory port and the shared divider keep these steps in series.
// Reset is synchronous; the frame memory needs no clearing pass.
// A finished item waits in the output register while out_stall is high.
// ---------------------------------------------------------------------------
`include "temporal_frame_combiner_top_defines.svh"
module temporal_frame_combiner_top
  import tfc_pkg::*;
#(
  parameter int unsigned MAX_FRAMES = MAX_FRAMES_DEF,
  parameter int unsigned MAX_PIXELS = MAX_PIXELS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           in_red,
  input  logic [7:0]           in_green,
  input  logic [7:0]           in_blue,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [7:0]           out_red,
  output logic [7:0]           out_green,
  output logic [7:0]           out_blue,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int unsigned SLOT_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int unsigned POS_W  = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int unsigned ADDR_W = SLOT_W + POS_W;
  localparam int unsigned CNT_W  = $clog2(MAX_FRAMES + 1);
  localparam int unsigned PIX_W  = $clog2(MAX_PIXELS + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_WRITE, S_READ, S_ACC, S_DIV, S_OUT
  } state_t;

  state_t state_r;
  logic [3:0]  op_mode_r;
  logic [3:0]  frame_depth_r;
  logic [14:0] frame_pixels_r;
  logic        primed_r;
  logic [SLOT_W-1:0] write_slot_r;
  logic [POS_W-1:0]  pos_r;
  logic [SLOT_W-1:0] slot_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [CNT_W-1:0]  depth_c;
  logic [PIX_W-1:0]  pixels_c;
  logic [23:0] px_r;
  logic [SUM_W-1:0] sum_r [3];
  logic [7:0]  acc_r [3];
  logic [1:0]  ch_r;
  logic        rd_pend_r;
  logic        avg_c;
  logic        mem_we;
  logic [ADDR_W-1:0] mem_addr;
  logic [23:0] mem_rdata;
  logic        div_start;
  logic        div_done;
  logic [7:0]  div_q;
  logic [SLOT_W-1:0] rd_slot;
  logic [7:0]  e [3];
  logic        div_restart;
  logic        div_kick_r;

  always_comb begin
    if (frame_depth_r == 4'd0) begin
      depth_c = CNT_W'(1);
    end else if (32'(frame_depth_r) > MAX_FRAMES) begin
      depth_c = CNT_W'(MAX_FRAMES);
    end else begin
      depth_c = CNT_W'(frame_depth_r);
    end
    if (frame_pixels_r == 15'd0) begin
      pixels_c = PIX_W'(1);
    end else if (32'(frame_pixels_r) > MAX_PIXELS) begin
      pixels_c = PIX_W'(MAX_PIXELS);
    end else begin
      pixels_c = PIX_W'(frame_pixels_r);
    end
  end

  assign avg_c   = (op_mode_r == MODE_AVG) || (op_mode_r > MODE_MAX);
  assign rd_slot = cnt_r[SLOT_W-1:0];
  assign mem_we  = (state_r == S_WRITE);
  assign mem_addr = (state_r == S_WRITE) ?
                    {(primed_r ? slot_r : cnt_r[SLOT_W-1:0]), pos_r} : {rd_slot, pos_r};
  assign e[0] = mem_rdata[23:16];
  assign e[1] = mem_rdata[15:8];
  assign e[2] = mem_rdata[7:0];
  assign div_start = ((state_r == S_ACC) && (cnt_r == depth_c) && !rd_pend_r && avg_c) ||
                     div_kick_r;

  tfc_store #(.ADDR_W(ADDR_W)) u_store (
    .clk(clk), .we(mem_we), .addr(mem_addr), .wdata(px_r), .rdata(mem_rdata)
  );

  tfc_divider u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(sum_r[ch_r]),
    .divisor(4'(depth_c)), .done(div_done), .quotient(div_q)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_red   = acc_r[0];
  assign out_green = acc_r[1];
  assign out_blue  = acc_r[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      op_mode_r      <= MODE_AVG;
      frame_depth_r  <= 4'd6;
      frame_pixels_r <= 15'd16384;
      primed_r       <= 1'b0;
      write_slot_r   <= '0;
      pos_r          <= '0;
      cnt_r          <= '0;
      rd_pend_r      <= 1'b0;
      ch_r           <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_OP_MODE:      op_mode_r      <= cfg_data[3:0];
          REG_FRAME_DEPTH:  frame_depth_r  <= cfg_data[3:0];
          REG_FRAME_PIXELS: frame_pixels_r <= cfg_data[14:0];
          default: ;
        endcase
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            px_r    <= {in_red, in_green, in_blue};
            acc_r[0] <= in_red;
            acc_r[1] <= in_green;
            acc_r[2] <= in_blue;
            for (int c = 0; c < 3; c++) sum_r[c] <= '0;
            slot_r  <= (CNT_W'(write_slot_r) < depth_c) ? write_slot_r : '0;
            cnt_r   <= '0;
            ch_r    <= '0;
            state_r <= S_WRITE;
          end
        end
        S_WRITE: begin
          if (primed_r || cnt_r + CNT_W'(1) >= depth_c) begin
            cnt_r   <= '0;
            state_r <= S_READ;
          end else begin
            cnt_r <= cnt_r + CNT_W'(1);
          end
        end
        S_READ: begin
          rd_pend_r <= 1'b1;
          cnt_r     <= cnt_r + CNT_W'(1);
          state_r   <= S_ACC;
        end
        S_ACC: begin
          if (rd_pend_r) begin
            for (int c = 0; c < 3; c++) begin
              sum_r[c] <= sum_r[c] + SUM_W'(e[c]);
              acc_r[c] <= fold8(op_mode_r, acc_r[c], e[c]);
            end
            if (cnt_r < depth_c) begin
              cnt_r <= cnt_r + CNT_W'(1);
            end else begin
              rd_pend_r <= 1'b0;
            end
          end else if (avg_c) begin
            ch_r    <= '0;
            state_r <= S_DIV;
          end else begin
            state_r <= S_OUT;
          end
        end
        S_DIV: begin
          if (div_done) begin
            acc_r[ch_r] <= div_q;
            if (ch_r == 2'd2) begin
              state_r <= S_OUT;
            end else begin
              ch_r <= ch_r + 2'd1;
            end
          end
        end
        S_OUT: begin
          if (!out_stall) begin
            state_r <= S_IDLE;
            if (32'(pos_r) + 32'd1 >= 32'(pixels_c)) begin
              pos_r    <= '0;
              primed_r <= 1'b1;
              write_slot_r <= (CNT_W'(slot_r) + CNT_W'(1) >= depth_c) ?
                              '0 : slot_r + SLOT_W'(1);
            end else begin
              pos_r <= pos_r + POS_W'(1);
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // The divider is restarted for each further channel while it is idle.
  assign div_restart = (state_r == S_DIV) && div_done && (ch_r != 2'd2);
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_kick_r <= 1'b0;
    end else begin
      div_kick_r <= div_restart;
    end
  end

  `TFC_ASSERT_IMP(a_stall_busy, state_r != S_IDLE, in_stall)
  `TFC_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_red))
  `TFC_ASSERT_IMP(a_pos_range, 1'b1, 32'(pos_r) < MAX_PIXELS)

endmodule

// ===== tb/sv/tb_temporal_frame_combiner_top.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Testbench for the temporal frame combiner
// Streams RGB pixels through the block under random input gaps and output
// stalls. A cycle-free predictor keeps its own frame ring and register
// copies and checks every combined pixel in order of arrival.
// ---------------------------------------------------------------------------
module tb_temporal_frame_combiner_top;
  import tfc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 800000;
  localparam int unsigned SETTLE      = 120;
  localparam int unsigned SMALL_FRAME = 16;
  localparam logic [3:0]  MODE_UNUSED = 4'd15;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  logic           clk;
  logic           rst_n;
  logic           in_valid;
  logic           in_stall;
  logic [7:0]     in_red;
  logic [7:0]     in_green;
  logic [7:0]     in_blue;
  logic           out_valid;
  logic           out_stall = 1'b0;
  logic [7:0]     out_red;
  logic [7:0]     out_green;
  logic [7:0]     out_blue;
  logic           cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  rgb_t        combined_q[$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned idle_pct;
  int unsigned items_sent;

  logic [23:0] ring_mem [MAX_FRAMES_DEF][MAX_PIXELS_DEF];
  bit          ring_primed;
  int unsigned ring_slot;
  int unsigned ring_pos;
  logic [3:0]  sh_mode;
  logic [3:0]  sh_depth;
  logic [14:0] sh_pixels;

  temporal_frame_combiner_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_red    (in_red),
    .in_green  (in_green),
    .in_blue   (in_blue),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_red   (out_red),
    .out_green (out_green),
    .out_blue  (out_blue),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("** temporal_frame_combiner_top: FAILED **");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < idle_pct);
  end

  function automatic logic [7:0] chan_fold(logic [3:0] m, logic [7:0] y, logic [7:0] x);
    logic [15:0] p;
    p = y * x;
    case (m)
      MODE_XOR: return y ^ x;
      MODE_OR:  return y | x;
      MODE_AND: return y & x;
      MODE_ADD: return y + x;
      MODE_SUB: return y - x;
      MODE_MUL: return p[7:0];
      MODE_MIN: return (x < y) ? x : y;
      MODE_MAX: return (x > y) ? x : y;
      default:  return y;
    endcase
  endfunction

  function automatic rgb_t combine_pixel(rgb_t px);
    int unsigned depth, pixels, pos, slot, s;
    int unsigned sr, sg, sb;
    rgb_t        e, y;
    depth  = (sh_depth == 0) ? 1 : (sh_depth > MAX_FRAMES_DEF) ? MAX_FRAMES_DEF : sh_depth;
    pixels = (sh_pixels == 0) ? 1 : (sh_pixels > MAX_PIXELS_DEF) ? MAX_PIXELS_DEF : sh_pixels;
    pos    = ring_pos % MAX_PIXELS_DEF;
    slot   = (ring_slot < depth) ? ring_slot : 0;
    if (!ring_primed) begin
      for (s = 0; s < depth; s++) ring_mem[s][pos] = px;
    end
    ring_mem[slot][pos] = px;
    y = px;
    sr = 0;
    sg = 0;
    sb = 0;
    for (s = 0; s < depth; s++) begin
      e = ring_mem[s][pos];
      sr += e.red;
      sg += e.green;
      sb += e.blue;
      y.red   = chan_fold(sh_mode, y.red, e.red);
      y.green = chan_fold(sh_mode, y.green, e.green);
      y.blue  = chan_fold(sh_mode, y.blue, e.blue);
    end
    if (sh_mode == MODE_AVG || sh_mode > MODE_MAX) begin
      y.red   = 8'(sr / depth);
      y.green = 8'(sg / depth);
      y.blue  = 8'(sb / depth);
    end
    if (pos + 1 >= pixels) begin
      ring_pos    = 0;
      ring_primed = 1'b1;
      ring_slot   = (slot + 1 >= depth) ? 0 : slot + 1;
    end else begin
      ring_pos = pos + 1;
    end
    return y;
  endfunction

  always @(posedge clk) begin
    rgb_t got, want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_red, out_green, out_blue};
      if (combined_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        want = combined_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %h actual %h", want, got);
        end
      end
    end
  end

  task automatic send_pixel(rgb_t px);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_red   <= px.red;
    in_green <= px.green;
    in_blue  <= px.blue;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    combined_q = {combined_q, combine_pixel(px)};
    items_sent++;
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (combined_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_OP_MODE:      sh_mode = val[3:0];
      REG_FRAME_DEPTH:  sh_depth = val[3:0];
      REG_FRAME_PIXELS: sh_pixels = val;
      default: ;
    endcase
  endtask

  function automatic rgb_t rand_pixel();
    rgb_t p;
    p = 24'($urandom);
    if ($urandom_range(9) == 0) p.red = $urandom_range(1) ? 8'hFF : 8'h00;
    if ($urandom_range(9) == 0) p.green = $urandom_range(1) ? 8'hFF : 8'h00;
    if ($urandom_range(9) == 0) p.blue = $urandom_range(1) ? 8'hFF : 8'h00;
    return p;
  endfunction

  // The first frame fills all eight slots, so later small frames never read
  // an unwritten entry.
  task automatic test_first_frame;
    int i;
    write_reg(REG_OP_MODE, CFG_W'(MODE_AVG));
    write_reg(REG_FRAME_DEPTH, CFG_W'(8));
    write_reg(REG_FRAME_PIXELS, CFG_W'(SMALL_FRAME));
    for (i = 0; i < SMALL_FRAME; i++) begin
      case (i % 4)
        0: send_pixel(24'h000000);
        1: send_pixel(24'hFFFFFF);
        2: send_pixel(24'hFF00FF);
        default: send_pixel(rand_pixel());
      endcase
    end
    drain();
  endtask

  task automatic test_each_mode;
    logic [3:0] m;
    for (m = MODE_XOR; m <= MODE_MAX; m++) begin
      write_reg(REG_OP_MODE, CFG_W'(m));
      send_pixel(24'hFFFFFF);
      send_pixel(rand_pixel());
      drain();
    end
    write_reg(REG_OP_MODE, CFG_W'(MODE_UNUSED));
    send_pixel(24'h00FF00);
    drain();
  endtask

  // Depth zero acts as one, so a full-size frame only reads the slot that
  // each pixel has just written.
  task automatic test_large_frame;
    int i;
    write_reg(REG_FRAME_DEPTH, CFG_W'(0));
    write_reg(REG_FRAME_PIXELS, 15'h7FFF);
    write_reg(REG_OP_MODE, CFG_W'($urandom_range(15)));
    for (i = 0; i < 60; i++) send_pixel(rand_pixel());
    drain();
    write_reg(REG_FRAME_PIXELS, CFG_W'(0));
    send_pixel(rand_pixel());
    drain();
    write_reg(REG_FRAME_PIXELS, CFG_W'(MAX_PIXELS_DEF));
    send_pixel(rand_pixel());
    drain();
    write_reg(REG_FRAME_PIXELS, CFG_W'(1));
    send_pixel(rand_pixel());
    drain();
  endtask

  task automatic test_depth_clamp;
    int i;
    write_reg(REG_FRAME_DEPTH, CFG_W'(15));
    write_reg(REG_FRAME_PIXELS, CFG_W'(SMALL_FRAME));
    write_reg(REG_OP_MODE, CFG_W'(MODE_AVG));
    for (i = 0; i < 20; i++) send_pixel(rand_pixel());
    drain();
  endtask

  task automatic test_random_streams;
    int i, n, phase;
    phase = 0;
    while (items_sent < 1300) begin
      idle_pct = (phase == 3) ? 0 : 38;
      write_reg(REG_OP_MODE, CFG_W'($urandom_range(15)));
      write_reg(REG_FRAME_DEPTH, CFG_W'($urandom_range(15)));
      write_reg(REG_FRAME_PIXELS,
                CFG_W'(($urandom_range(7) == 0) ? 0 : $urandom_range(SMALL_FRAME, 1)));
      n = $urandom_range(120, 40);
      for (i = 0; i < n; i++) begin
        send_pixel(rand_pixel());
        if (phase == 1 && i == n / 2) begin
          in_valid <= 1'b0;
          @(posedge clk);
          while (combined_q.size() != 0) @(posedge clk);
        end
        if ($urandom_range(49) == 0) begin
          drain();
          write_reg(REG_FRAME_PIXELS, CFG_W'($urandom_range(SMALL_FRAME, 1)));
        end
      end
      drain();
      phase++;
    end
    idle_pct = 38;
  endtask

  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_red     = '0;
    in_green   = '0;
    in_blue    = '0;
    cfg_we     = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    items_sent = 0;
    idle_pct   = 38;
    ring_primed = 1'b0;
    ring_slot  = 0;
    ring_pos   = 0;
    sh_mode    = MODE_AVG;
    sh_depth   = 4'd6;
    sh_pixels  = 15'd16384;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_first_frame();
    test_each_mode();
    test_large_frame();
    test_depth_clamp();
    test_random_streams();
    drain();
    if (mismatches == 0 && combined_q.size() == 0) begin
      $display("** temporal_frame_combiner_top: PASSED **");
    end else begin
      $display("** temporal_frame_combiner_top: FAILED **");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+design
design/tfc_pkg.sv
design/tfc_store.sv
design/tfc_divider.sv
design/temporal_frame_combiner_top.sv
tb/sv/tb_temporal_frame_combiner_top.sv
